FILE: rtl/tib_pkg.sv
// ----------------------------------------------------------------------------
// tib_pkg: shared types and codes for the timer bank
// Sizes, request and status codes, scan state and the slot update record.
// ----------------------------------------------------------------------------
package tib_pkg;

  // Sizing
  localparam int NUM_TIMERS  = 16;
  localparam int TIME_WIDTH  = 32;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [3:0]            id_t;
  typedef logic [2:0]            status_t;
  typedef logic [3:0]            mode_t;

  localparam slot_t LAST_SLOT = slot_t'(NUM_TIMERS - 1);

  // Request modes
  localparam mode_t MODE_ADD_ONE   = 4'd0;
  localparam mode_t MODE_ADD_PER   = 4'd1;
  localparam mode_t MODE_ALTER_ONE = 4'd2;
  localparam mode_t MODE_ALTER_PER = 4'd3;
  localparam mode_t MODE_DIS_ONE   = 4'd4;
  localparam mode_t MODE_DIS_PER   = 4'd5;
  localparam mode_t MODE_EXIST_ONE = 4'd6;
  localparam mode_t MODE_EXIST_PER = 4'd7;
  localparam mode_t MODE_TICK      = 4'd8;

  // Result status codes
  localparam status_t STAT_OK        = 3'd0;
  localparam status_t STAT_NOT_FOUND = 3'd1;
  localparam status_t STAT_FULL      = 3'd2;
  localparam status_t STAT_FIRED     = 3'd3;
  localparam status_t STAT_NONE      = 3'd4;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  // Outcome of one slot on a tick
  typedef struct packed {
    logic  fire;
    time_t new_time;
  } upd_t;

endpackage

FILE: rtl/tib_update.sv
// ----------------------------------------------------------------------------
// tib_update: per-slot tick arithmetic
// Decides whether a slot fires and computes its new remaining time.
// ----------------------------------------------------------------------------
module tib_update (
  input  tib_pkg::time_t time_left,
  input  tib_pkg::time_t reload,
  input  tib_pkg::time_t elapsed,
  input  logic           periodic,
  output tib_pkg::upd_t  upd
);

  // reload - (elapsed - left) as one three-operand sum, two guard bits for sign
  logic [tib_pkg::TIME_WIDTH+1:0] reload_sum;
  logic                           reload_pos;
  tib_pkg::time_t                 remain;
  logic                           fire;

  assign reload_sum = {2'b00, reload} + {2'b00, time_left} - {2'b00, elapsed};
  assign reload_pos = !reload_sum[tib_pkg::TIME_WIDTH+1] && (reload_sum != '0);
  assign remain     = time_left - elapsed;
  assign fire       = (time_left <= elapsed);

  always_comb begin
    upd.fire = fire;
    if (!fire) begin
      upd.new_time = remain;
    end else if (periodic && reload_pos) begin
      upd.new_time = reload_sum[tib_pkg::TIME_WIDTH-1:0];
    end else begin
      upd.new_time = '0;
    end
  end

endmodule

FILE: rtl/timeout_interval_timer_bank.sv
// ----------------------------------------------------------------------------
// timeout_interval_timer_bank: slot table of one-shot and periodic timers
// Add, alter, disable and query timers by slot; a tick fires expired timers.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_mode, in_timer_id, in_time_value) is taken on a rising edge
//   with start high and busy low. Results appear on the out_ ports for one
//   cycle each, flagged by out_valid; out_last marks the final result of a
//   request. The receiver cannot stall, so results are never held back.
//   Add, alter, disable and exists finish in the accept cycle: the single
//   result shows the next cycle and busy stays low, one request per cycle.
//   Unused modes give no result.
//   A tick scans the slot memories twice (one-shots, then periodic), one slot
//   per cycle through the registered read of the time memories, then
//   drains and flushes a one-deep result buffer, with busy high throughout.
//   Firings stream out during the scan; the final one (or a "nothing fired"
//   result) shows after the scan.
//   Reset clears the live flags and returns the sequencer to idle; the time
//   memories need no clearing since a slot is written when it is added.
// ----------------------------------------------------------------------------
module timeout_interval_timer_bank (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tib_pkg::mode_t      in_mode,
  input  tib_pkg::id_t        in_timer_id,
  input  logic [31:0]         in_time_value,
  output logic                out_valid,
  output tib_pkg::status_t    out_status,
  output tib_pkg::id_t        out_slot_id,
  output logic                out_present,
  output logic                out_last
);

  // Slot flags in flops, times in memories
  logic [tib_pkg::NUM_TIMERS-1:0] live_r, live_nxt;
  logic [tib_pkg::NUM_TIMERS-1:0] per_r, per_nxt;
  tib_pkg::time_t                 tl_mem [tib_pkg::NUM_TIMERS];
  tib_pkg::time_t                 rp_mem [tib_pkg::NUM_TIMERS];
  tib_pkg::time_t                 tl_rdata_r, rp_rdata_r;

  logic                           tl_we, rp_we;
  tib_pkg::slot_t                 tl_waddr, rp_waddr;
  tib_pkg::time_t                 tl_wdata, rp_wdata;

  // Sequencer
  tib_pkg::state_t                state_r, state_nxt;
  tib_pkg::slot_t                 rd_idx_r, rd_idx_nxt;
  logic                           pass_r, pass_nxt;
  logic                           proc_valid_r, proc_valid_nxt;
  tib_pkg::slot_t                 proc_idx_r, proc_idx_nxt;
  logic                           proc_pass_r, proc_pass_nxt;
  tib_pkg::time_t                 elapsed_r, elapsed_nxt;
  tib_pkg::cnt_t                  cnt_r, cnt_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  tib_pkg::slot_t                 pend_slot_r, pend_slot_nxt;

  // Output registers
  logic                           out_valid_r, out_valid_nxt;
  tib_pkg::status_t               out_status_r, out_status_nxt;
  tib_pkg::id_t                   out_slot_r, out_slot_nxt;
  logic                           out_present_r, out_present_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           accept;
  tib_pkg::time_t                 tv;
  logic                           id_ok;
  tib_pkg::slot_t                 id_slot;
  logic                           match;
  logic                           free_found;
  tib_pkg::slot_t                 free_idx;
  logic                           act;
  tib_pkg::upd_t                  upd;

  assign busy        = (state_r != tib_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign tv          = tib_pkg::time_t'(in_time_value);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_slot_id = out_slot_r;
  assign out_present = out_present_r;
  assign out_last    = out_last_r;

  // Slot lookup for alter / disable / exists
  assign id_ok   = (int'(in_timer_id) < tib_pkg::NUM_TIMERS);
  assign id_slot = tib_pkg::slot_t'(in_timer_id);
  assign match   = id_ok && live_r[id_slot] && (per_r[id_slot] == in_mode[0]);

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = tib_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_found = 1'b1;
        free_idx   = tib_pkg::slot_t'(i);
      end
    end
  end

  // Tick arithmetic for the slot whose data just came out of the memories
  tib_update u_update (
    .time_left (tl_rdata_r),
    .reload    (rp_rdata_r),
    .elapsed   (elapsed_r),
    .periodic  (proc_pass_r),
    .upd       (upd)
  );

  assign act = proc_valid_r && live_r[proc_idx_r] && (per_r[proc_idx_r] == proc_pass_r);

  // Next-state logic
  always_comb begin
    state_nxt       = state_r;
    rd_idx_nxt      = rd_idx_r;
    pass_nxt        = pass_r;
    proc_valid_nxt  = 1'b0;
    proc_idx_nxt    = proc_idx_r;
    proc_pass_nxt   = proc_pass_r;
    elapsed_nxt     = elapsed_r;
    cnt_nxt         = cnt_r;
    pend_valid_nxt  = pend_valid_r;
    pend_slot_nxt   = pend_slot_r;
    live_nxt        = live_r;
    per_nxt         = per_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;
    tl_we           = 1'b0;
    rp_we           = 1'b0;
    tl_waddr        = id_slot;
    rp_waddr        = id_slot;
    tl_wdata        = tv;
    rp_wdata        = tv;

    unique case (state_r)
      tib_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt   = 1'b1;
          out_present_nxt = 1'b0;
          out_last_nxt    = 1'b1;
          out_slot_nxt    = in_timer_id;
          unique case (in_mode)
            tib_pkg::MODE_ADD_ONE, tib_pkg::MODE_ADD_PER: begin
              if (free_found) begin
                live_nxt[free_idx] = 1'b1;
                per_nxt[free_idx]  = in_mode[0];
                tl_we              = 1'b1;
                rp_we              = 1'b1;
                tl_waddr           = free_idx;
                rp_waddr           = free_idx;
                out_status_nxt     = tib_pkg::STAT_OK;
                out_slot_nxt       = tib_pkg::id_t'(free_idx);
              end else begin
                out_status_nxt = tib_pkg::STAT_FULL;
                out_slot_nxt   = '0;
              end
            end
            tib_pkg::MODE_ALTER_ONE, tib_pkg::MODE_ALTER_PER: begin
              // one-shot: remaining time; periodic: period only
              if (match) begin
                tl_we          = !in_mode[0];
                rp_we          = in_mode[0];
                out_status_nxt = tib_pkg::STAT_OK;
              end else begin
                out_status_nxt = tib_pkg::STAT_NOT_FOUND;
              end
            end
            tib_pkg::MODE_DIS_ONE, tib_pkg::MODE_DIS_PER: begin
              if (match) begin
                live_nxt[id_slot] = 1'b0;
                out_status_nxt    = tib_pkg::STAT_OK;
              end else begin
                out_status_nxt = tib_pkg::STAT_NOT_FOUND;
              end
            end
            tib_pkg::MODE_EXIST_ONE, tib_pkg::MODE_EXIST_PER: begin
              out_status_nxt  = tib_pkg::STAT_OK;
              out_present_nxt = match;
            end
            tib_pkg::MODE_TICK: begin
              out_valid_nxt  = 1'b0;
              state_nxt      = tib_pkg::ST_SCAN;
              rd_idx_nxt     = '0;
              pass_nxt       = 1'b0;
              elapsed_nxt    = tv;
              cnt_nxt        = '0;
              pend_valid_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      tib_pkg::ST_SCAN: begin
        // issue one read per cycle, one-shot pass then periodic pass
        proc_valid_nxt = 1'b1;
        proc_idx_nxt   = rd_idx_r;
        proc_pass_nxt  = pass_r;
        if (rd_idx_r == tib_pkg::LAST_SLOT) begin
          rd_idx_nxt = '0;
          if (pass_r) begin
            state_nxt = tib_pkg::ST_DRAIN;
          end else begin
            pass_nxt = 1'b1;
          end
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      tib_pkg::ST_DRAIN: begin
        state_nxt = tib_pkg::ST_FIN;
      end
      tib_pkg::ST_FIN: begin
        // flush the held firing as the last result, or report none
        out_valid_nxt   = 1'b1;
        out_present_nxt = 1'b0;
        out_last_nxt    = 1'b1;
        if (pend_valid_r) begin
          out_status_nxt = tib_pkg::STAT_FIRED;
          out_slot_nxt   = tib_pkg::id_t'(pend_slot_r);
        end else begin
          out_status_nxt = tib_pkg::STAT_NONE;
          out_slot_nxt   = '0;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = tib_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tib_pkg::ST_IDLE;
      end
    endcase

    // Slot update, in the cycle after the read.
    // Reads never hit the slot being written.
    if (act) begin
      tl_we    = 1'b1;
      tl_waddr = proc_idx_r;
      tl_wdata = upd.new_time;
      if (upd.fire && !proc_pass_r) begin
        live_nxt[proc_idx_r] = 1'b0;
      end
      if (upd.fire && (cnt_r < tib_pkg::MAX_RESULTS)) begin
        // hold each firing until the next one shows whether it is the last
        if (pend_valid_r) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = tib_pkg::STAT_FIRED;
          out_slot_nxt    = tib_pkg::id_t'(pend_slot_r);
          out_present_nxt = 1'b0;
          out_last_nxt    = 1'b0;
        end
        pend_valid_nxt = 1'b1;
        pend_slot_nxt  = proc_idx_r;
        cnt_nxt        = cnt_r + 1'b1;
      end
    end
  end

  // Time memories: one write port each, shared registered read
  always_ff @(posedge clk) begin
    if (tl_we) begin
      tl_mem[tl_waddr] <= tl_wdata;
    end
    if (rp_we) begin
      rp_mem[rp_waddr] <= rp_wdata;
    end
    tl_rdata_r <= tl_mem[rd_idx_r];
    rp_rdata_r <= rp_mem[rd_idx_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tib_pkg::ST_IDLE;
      live_r       <= '0;
      proc_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      rd_idx_r     <= '0;
      pass_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_r       <= live_nxt;
      proc_valid_r <= proc_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      rd_idx_r     <= rd_idx_nxt;
      pass_r       <= pass_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    per_r         <= per_nxt;
    proc_idx_r    <= proc_idx_nxt;
    proc_pass_r   <= proc_pass_nxt;
    elapsed_r     <= elapsed_nxt;
    pend_slot_r   <= pend_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_present_r <= out_present_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Assertions
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tib_pkg::ST_FIN |=> out_valid && out_last)
    else $error("tick did not end with a last result");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tib_pkg::ST_IDLE && !start |=> !out_valid)
    else $error("result without a request");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tib_pkg::MAX_RESULTS)
    else $error("firing count beyond cap");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == tib_pkg::MODE_TICK |=> busy)
    else $error("tick accepted but scan not started");

  a_fired_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tib_pkg::STAT_FIRED |-> $past(state_r) != tib_pkg::ST_IDLE)
    else $error("firing reported outside a tick");

endmodule
